@@ design/kwm_pkg.sv @@
// Package with the word types, queue command type and constants of the k-way merge block.
`default_nettype none

package kwm_pkg;

  localparam int WAYS_DEFAULT = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int WAY_W = 5;
  localparam int KEY_W = 29;
  localparam int PAY_W = 32;
  localparam int CFG_W = 6;

  typedef struct packed {
    logic [WAY_W-1:0] way;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
    logic             end_of_run;
  } in_word_t;

  typedef struct packed {
    logic [KEY_W-1:0] out_key;
    logic [PAY_W-1:0] out_payload;
    logic [WAY_W-1:0] out_way;
    logic             all_done;
  } out_word_t;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_END  = 2'd1,
    CMD_SKIP = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [WAY_W-1:0] way;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } cmd_t;

endpackage

`default_nettype wire

@@ design/kwm_front.sv @@
// Input side: accepts words and classifies them into load, end or skip commands.
`default_nettype none

module kwm_front import kwm_pkg::*; #(
  parameter int WAYS = WAYS_DEFAULT
) (
  input  wire logic                       src_valid,
  output logic                            src_stall,
  input  wire in_word_t                   src_data,
  input  wire logic [$clog2(WAYS+1)-1:0]  live_ways,
  input  wire logic                       q_full,
  output logic                            q_push,
  output cmd_t                            q_cmd
);

  assign src_stall = q_full;
  assign q_push    = src_valid && !q_full;

  always_comb begin
    q_cmd.way     = src_data.way;
    q_cmd.key     = src_data.key;
    q_cmd.payload = src_data.payload;
    priority if (int'(src_data.way) >= int'(live_ways)) begin
      q_cmd.kind = CMD_SKIP;
    end else if (src_data.end_of_run) begin
      q_cmd.kind = CMD_END;
    end else begin
      q_cmd.kind = CMD_LOAD;
    end
  end

endmodule

`default_nettype wire

@@ design/kwm_queue.sv @@
// Short command queue between the input side and the merge engine.
`default_nettype none

module kwm_queue import kwm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output cmd_t      pop_cmd
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          entry [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = (int'(count) == QUEUE_DEPTH);
  assign empty   = (count == '0);
  assign pop_cmd = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (int'(wr_ptr) == QUEUE_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (int'(rd_ptr) == QUEUE_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/kwm_back.sv @@
// Merge engine: updates the way heads, scans for the smallest key and holds the output word.
`default_nettype none

module kwm_back import kwm_pkg::*; #(
  parameter int WAYS = WAYS_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [$clog2(WAYS+1)-1:0]  live_ways,
  input  wire logic                       q_empty,
  output logic                            q_pop,
  input  wire cmd_t                       q_cmd,
  output logic                            dst_valid,
  input  wire logic                       dst_stall,
  output out_word_t                       dst_data
);

  localparam int NW = $clog2(WAYS + 1);
  localparam int IW = $clog2(WAYS);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_SCAN  = 5'b00100,
    S_FETCH = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  logic [KEY_W-1:0] key_mem [WAYS];
  logic [PAY_W-1:0] pay_mem [WAYS];
  logic [WAYS-1:0]  head_valid;
  logic [WAYS-1:0]  way_exhausted;
  logic             done_sent;

  logic [NW-1:0]    scan_idx;
  logic [IW-1:0]    rd_addr;
  logic [KEY_W-1:0] rd_key;
  logic [PAY_W-1:0] rd_pay;
  logic             cmp_vld;
  logic [IW-1:0]    cmp_idx;
  logic             found;
  logic [KEY_W-1:0] best_key;
  logic [IW-1:0]    best_idx;
  logic             res_done;

  logic [WAYS-1:0]  need_mask;
  logic             all_ready;
  logic             any_head;
  logic             out_free;
  logic             scan_live;

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      need_mask[i] = (i < int'(live_ways));
    end
  end

  assign all_ready = &(~need_mask | head_valid | way_exhausted);
  assign any_head  = |(need_mask & head_valid);
  assign out_free  = !dst_valid || !dst_stall;
  assign q_pop     = (state == S_IDLE) && !q_empty;
  assign scan_live = (scan_idx < live_ways);
  assign rd_addr   = (state == S_SCAN) ? scan_idx[IW-1:0] : best_idx;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (!q_empty) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (all_ready && any_head) begin
          state_next = S_SCAN;
        end else if (all_ready && !done_sent) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (!scan_live) begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.kind == CMD_LOAD && !way_exhausted[IW'(q_cmd.way)]) begin
      key_mem[IW'(q_cmd.way)] <= q_cmd.key;
      pay_mem[IW'(q_cmd.way)] <= q_cmd.payload;
    end
    rd_key <= key_mem[rd_addr];
    rd_pay <= pay_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    cmp_idx <= scan_idx[IW-1:0];
    if (state == S_SCAN) begin
      scan_idx <= scan_idx + 1'b1;
    end else begin
      scan_idx <= '0;
    end
    if (state == S_CHECK) begin
      res_done <= !any_head;
    end
    if (cmp_vld && (!found || rd_key < best_key)) begin
      best_key <= rd_key;
      best_idx <= cmp_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      head_valid    <= '0;
      way_exhausted <= '0;
      done_sent     <= 1'b0;
      cmp_vld       <= 1'b0;
      found         <= 1'b0;
      dst_valid     <= 1'b0;
    end else begin
      state   <= state_next;
      cmp_vld <= (state == S_SCAN) && scan_live && head_valid[scan_idx[IW-1:0]];
      if (state == S_CHECK) begin
        found <= 1'b0;
      end else if (cmp_vld) begin
        found <= 1'b1;
      end
      if (q_pop) begin
        if (q_cmd.kind == CMD_END) begin
          way_exhausted[IW'(q_cmd.way)] <= 1'b1;
        end else if (q_cmd.kind == CMD_LOAD && !way_exhausted[IW'(q_cmd.way)]) begin
          head_valid[IW'(q_cmd.way)] <= 1'b1;
        end
      end
      if (state == S_EMIT && out_free) begin
        dst_valid <= 1'b1;
        if (res_done) begin
          done_sent <= 1'b1;
        end else begin
          head_valid[best_idx] <= 1'b0;
        end
      end else if (!dst_stall) begin
        dst_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      if (res_done) begin
        dst_data.out_key     <= '0;
        dst_data.out_payload <= '0;
        dst_data.out_way     <= '0;
        dst_data.all_done    <= 1'b1;
      end else begin
        dst_data.out_key     <= best_key;
        dst_data.out_payload <= rd_pay;
        dst_data.out_way     <= WAY_W'(best_idx);
        dst_data.all_done    <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/kway_merge_min_select.sv @@
// Top level of the k-way merge block: ways register, input side, queue and merge engine.
//
//   channel | valid     | stall     | word
//   --------+-----------+-----------+-----------------------------
//   input   | src_valid | src_stall | src_data  (in_word_t)
//   output  | dst_valid | dst_stall | dst_data  (out_word_t)
//   config  | cfg_wr_en | -         | cfg_wr_data (active ways)
//
// An item that emits nothing goes from idle to check and back to idle in the merge engine.
// An item that emits a record passes the check, scan, fetch and emit states; its
// scan reads one way head per cycle from the key memory.
// A two-word queue lets the input side keep accepting while the engine works.
// A finished word waits in the output register while the next item is taken.
// Reset clears all head and exhausted marks and sets active ways to 32, or to WAYS if smaller.
`default_nettype none

module kway_merge_min_select import kwm_pkg::*; #(
  parameter int WAYS = WAYS_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             src_valid,
  output logic                  src_stall,
  input  wire in_word_t         src_data,
  output logic                  dst_valid,
  input  wire logic             dst_stall,
  output out_word_t             dst_data,
  input  wire logic             cfg_wr_en,
  input  wire logic [CFG_W-1:0] cfg_wr_data
);

  localparam int NW = $clog2(WAYS + 1);
  localparam logic [CFG_W-1:0] AW_RESET = CFG_W'((32 < WAYS) ? 32 : WAYS);

  logic [CFG_W-1:0] active_ways;
  logic [NW-1:0]    live_ways;
  logic             q_full;
  logic             q_push;
  logic             q_empty;
  logic             q_pop;
  cmd_t             push_cmd;
  cmd_t             pop_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_ways <= AW_RESET;
    end else if (cfg_wr_en) begin
      active_ways <= cfg_wr_data;
    end
  end

  always_comb begin
    priority if (int'(active_ways) > WAYS) begin
      live_ways = NW'(WAYS);
    end else if (active_ways == '0) begin
      live_ways = NW'(1);
    end else begin
      live_ways = NW'(active_ways);
    end
  end

  kwm_front #(.WAYS(WAYS)) u_front (
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .live_ways (live_ways),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  kwm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_cmd  (pop_cmd)
  );

  kwm_back #(.WAYS(WAYS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .live_ways (live_ways),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_cmd     (pop_cmd),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_data  (dst_data)
  );

`ifndef SYNTHESIS
  a_done_fields_zero: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_data.all_done |->
      dst_data.out_key == '0 && dst_data.out_payload == '0 && dst_data.out_way == '0)
    else $error("Done word carries nonzero record fields.");

  a_done_once: assert property (@(posedge clk) disable iff (rst)
    dst_valid && !dst_stall && dst_data.all_done |=> !(dst_valid && dst_data.all_done))
    else $error("Done word repeated.");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("Engine took a word from an empty queue.");
`endif

endmodule

`default_nettype wire

@@ dv/tb_kway_merge_min_select.sv @@
// Self-checking testbench that feeds sorted runs to the k-way merge block and checks each output word.
`timescale 1ns / 100ps

module tb_kway_merge_min_select;
  import kwm_pkg::*;

  localparam int NUM_WAYS = WAYS_DEFAULT;
  localparam longint KEY_MAX = (longint'(1) << KEY_W) - 1;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst;
  logic src_valid;
  logic src_stall;
  in_word_t src_data;
  logic dst_valid;
  logic dst_stall;
  out_word_t dst_data;
  logic cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;

  bit [KEY_W-1:0] head_key [NUM_WAYS];
  bit [PAY_W-1:0] head_payload [NUM_WAYS];
  bit head_valid [NUM_WAYS];
  bit exhausted [NUM_WAYS];
  bit done_sent;
  logic [CFG_W-1:0] ways_cfg = 6'd32;
  out_word_t expected_words [$];

  int unsigned run_left [NUM_WAYS];
  longint run_key [NUM_WAYS];

  int cycle_count = 0;
  int mismatch_count = 0;
  int words_sent = 0;
  int useful_words = 0;
  int results_seen = 0;
  int done_seen = 0;
  int hold_request = 0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit tail_calm = 1'b0;

  always #2 clk = ~clk;

  kway_merge_min_select #(.WAYS(NUM_WAYS)) u_top (
    .clk(clk),
    .rst(rst),
    .src_valid(src_valid),
    .src_stall(src_stall),
    .src_data(src_data),
    .dst_valid(dst_valid),
    .dst_stall(dst_stall),
    .dst_data(dst_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  function automatic int live_ways();
    int n;
    n = ways_cfg;
    if (n < 1) n = 1;
    if (n > NUM_WAYS) n = NUM_WAYS;
    return n;
  endfunction

  // Updates the predicted heads for one accepted word and queues the word it should emit.
  // Returns 1 when the word changed the merge state.
  function automatic bit merge_step(input in_word_t w);
    int n;
    int i;
    int best;
    bit found;
    bit ready;
    bit took;
    out_word_t r;
    n = live_ways();
    best = 0;
    found = 1'b0;
    ready = 1'b1;
    took = 1'b0;
    if (w.way < n) begin
      if (w.end_of_run) begin
        took = !exhausted[w.way];
        exhausted[w.way] = 1'b1;
      end else if (!exhausted[w.way]) begin
        head_key[w.way] = w.key;
        head_payload[w.way] = w.payload;
        head_valid[w.way] = 1'b1;
        took = 1'b1;
      end
    end
    for (i = 0; i < n; i++) begin
      if (!head_valid[i] && !exhausted[i]) ready = 1'b0;
      if (ready && head_valid[i] && (!found || head_key[i] < head_key[best])) begin
        best = i;
        found = 1'b1;
      end
    end
    if (ready) begin
      r = '0;
      if (found) begin
        r.out_key = head_key[best];
        r.out_payload = head_payload[best];
        r.out_way = WAY_W'(best);
        head_valid[best] = 1'b0;
        expected_words.push_back(r);
      end else if (!done_sent) begin
        done_sent = 1'b1;
        r.all_done = 1'b1;
        expected_words.push_back(r);
      end
    end
    return took;
  endfunction

  function automatic in_word_t mk_word(input int unsigned way, input longint unsigned key,
                                       input longint unsigned payload, input bit eor);
    in_word_t w;
    w.way = WAY_W'(way);
    w.key = KEY_W'(key);
    w.payload = PAY_W'(payload);
    w.end_of_run = eor;
    return w;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 40) $display("MISMATCH cycle %0d: %s", cycle_count, what);
  endtask

  task automatic send_word(input in_word_t w);
    @(negedge clk);
    if (tx_idle_on && $urandom_range(0, 7) == 0) begin
      src_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    src_valid <= 1'b1;
    src_data <= w;
    @(posedge clk);
    while (src_stall !== 1'b0) @(posedge clk);
    words_sent++;
    if (merge_step(w)) useful_words++;
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    src_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_ways(input int value);
    wait_quiet();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= CFG_W'(value);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    ways_cfg = CFG_W'(value);
  endtask

  task automatic test_default_ways();
    send_word(mk_word(31, KEY_MAX, 0, 1'b0));
    write_ways(32);
    send_word(mk_word(30, 0, 32'hFFFF_FFFF, 1'b0));
  endtask

  task automatic test_single_way();
    write_ways(0);
    send_word(mk_word(0, KEY_MAX, 32'hFFFF_FFFF, 1'b0));
    send_word(mk_word(3, 123, 456, 1'b0));
    send_word(mk_word(0, 0, 0, 1'b0));
    write_ways(1);
    send_word(mk_word(0, 29'h0ABC_DEF0, 32'h1234_5678, 1'b0));
  endtask

  // Covers ties, ignored words, an end mark on a loaded head and the single done word.
  task automatic test_three_ways();
    write_ways(3);
    send_word(mk_word(1, 20, 32'h0000_0101, 1'b0));
    send_word(mk_word(1, 29'h1555_5555, 32'hAAAA_AAAA, 1'b1));
    send_word(mk_word(1, 5, 32'h0000_0102, 1'b0));
    send_word(mk_word(2, 20, 32'h0000_0201, 1'b0));
    send_word(mk_word(0, 20, 32'h0000_0001, 1'b0));
    send_word(mk_word(0, 0, 0, 1'b1));
    send_word(mk_word(31, 7, 32'h0000_1F01, 1'b0));
    send_word(mk_word(2, KEY_MAX, 32'h5555_5555, 1'b0));
    send_word(mk_word(2, 0, 0, 1'b1));
    send_word(mk_word(7, 9, 32'h0000_0701, 1'b0));
    send_word(mk_word(0, 3, 32'h0000_0002, 1'b0));
  endtask

  // Merges fresh sorted runs on ways first_way..last_way. Most words answer the way that
  // the merge asks for; the rest are stray records, stray end marks and ignored words.
  task automatic run_merge(input int cfg_value, input int first_way, input int last_way,
                           input int len_lo, input int len_hi, input int hold_at,
                           input int pause_at, input int calm_at);
    int n;
    int i;
    int pick;
    int phase_base;
    bit busy;
    int needy [$];
    int spent [$];
    in_word_t w;
    longint step;
    write_ways(cfg_value);
    for (i = first_way; i <= last_way; i++) begin
      run_left[i] = $urandom_range(len_lo, len_hi);
      case ($urandom_range(0, 3))
        0: run_key[i] = 0;
        1: run_key[i] = $urandom_range(0, 1000);
        default: run_key[i] = $urandom >> (32 - KEY_W);
      endcase
    end
    n = live_ways();
    phase_base = useful_words;
    busy = 1'b1;
    while (busy) begin
      needy.delete();
      spent.delete();
      busy = 1'b0;
      for (i = 0; i < n; i++) begin
        if (!exhausted[i] && !head_valid[i]) needy.push_back(i);
        if (exhausted[i]) spent.push_back(i);
        if (!exhausted[i] || head_valid[i]) busy = 1'b1;
      end
      if (busy) begin
        w = mk_word($urandom_range(0, NUM_WAYS - 1), $urandom >> (32 - KEY_W), $urandom,
                    $urandom_range(0, 11) == 0);
        if (needy.size() != 0 && $urandom_range(0, 99) >= 8) begin
          pick = needy[$urandom_range(0, needy.size() - 1)];
          w.way = WAY_W'(pick);
          if (run_left[pick] == 0) begin
            w.end_of_run = 1'b1;
          end else begin
            w.key = KEY_W'(run_key[pick]);
            w.end_of_run = 1'b0;
            run_left[pick]--;
            step = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1 << 26)
                                               : $urandom_range(0, 40);
            run_key[pick] = (run_key[pick] + step > KEY_MAX) ? KEY_MAX : run_key[pick] + step;
          end
        end else if (spent.size() != 0 && $urandom_range(0, 1) == 0) begin
          w.way = WAY_W'(spent[$urandom_range(0, spent.size() - 1)]);
          w.end_of_run = 1'b0;
        end
        send_word(w);
        if (!tail_calm && $urandom_range(0, 127) == 0) begin
          tx_idle_on = $urandom_range(0, 3) != 0;
          rx_idle_on = $urandom_range(0, 3) != 0;
        end
        if (useful_words - phase_base == hold_at) begin
          hold_request = HOLD_OFF_CYCLES;
          hold_at = -1;
        end
        if (useful_words - phase_base == pause_at) begin
          wait_quiet();
          pause_at = -1;
        end
        if (useful_words - phase_base == calm_at) begin
          tail_calm = 1'b1;
          tx_idle_on = 1'b0;
          rx_idle_on = 1'b0;
          calm_at = -1;
        end
      end
    end
  endtask

  task automatic test_merge_runs();
    run_merge(8, 3, 7, 20, 40, -1, -1, -1);
    run_merge(16, 8, 15, 25, 45, -1, -1, -1);
    run_merge(24, 16, 23, 30, 50, -1, -1, -1);
  endtask

  task automatic test_backpressure();
    run_merge(63, 24, 31, 50, 80, 100, 250, 350);
  endtask

  initial begin : rx_stall_gen
    int burst_left;
    int hold_left;
    burst_left = 0;
    hold_left = 0;
    dst_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        dst_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        dst_stall <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 11) == 0) begin
        burst_left = $urandom_range(0, 8);
        dst_stall <= 1'b1;
      end else begin
        dst_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_words
    out_word_t want;
    if (!rst && dst_valid === 1'b1 && dst_stall === 1'b0) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word way %0d key %0h done %0b",
                                  dst_data.out_way, dst_data.out_key, dst_data.all_done));
      end else begin
        want = expected_words.pop_front();
        results_seen++;
        if (want.all_done) done_seen++;
        if (dst_data.out_key !== want.out_key)
          report_mismatch($sformatf("out_key %0h, expected %0h", dst_data.out_key,
                                    want.out_key));
        if (dst_data.out_payload !== want.out_payload)
          report_mismatch($sformatf("out_payload %0h, expected %0h", dst_data.out_payload,
                                    want.out_payload));
        if (dst_data.out_way !== want.out_way)
          report_mismatch($sformatf("out_way %0d, expected %0d", dst_data.out_way,
                                    want.out_way));
        if (dst_data.all_done !== want.all_done)
          report_mismatch($sformatf("all_done %0b, expected %0b", dst_data.all_done,
                                    want.all_done));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding.", cycle_count,
               expected_words.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    src_valid = 1'b0;
    src_data = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_ways();
    test_single_way();
    test_three_ways();
    test_merge_runs();
    test_backpressure();
    wait_quiet();

    $display("Sent %0d input words (%0d changed merge state); checked %0d output words, %0d done.",
             words_sent, useful_words, results_seen, done_seen);
    $display("Active ways went through 32, 0, 1, 3, 8, 16, 24 and 63, with a long output hold.");
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/kwm_pkg.sv
design/kwm_front.sv
design/kwm_queue.sv
design/kwm_back.sv
design/kway_merge_min_select.sv
dv/tb_kway_merge_min_select.sv
